@@ rtl/vdpi_pkg.sv @@
`default_nettype none

package vdpi_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned ADDR_W     = 14;

  localparam logic [ADDR_W-1:0] ADDR_MASK   = 14'h3FFF;
  localparam logic [ADDR_W-1:0] NAME_MASK   = 14'h3800;
  localparam logic [ADDR_W-1:0] SPRITE_MASK = 14'h3F00;
  localparam logic [4:0]        CRAM_MASK   = 5'h1F;
  localparam logic [3:0]        REG_MASK    = 4'hF;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EVENT = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CMD_VRAM_READ  = 2'd0,
    CMD_VRAM_WRITE = 2'd1,
    CMD_REG_WRITE  = 2'd2,
    CMD_CRAM_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    BOP_NONE  = 2'd0,
    BOP_FILL  = 2'd1,
    BOP_READ  = 2'd2,
    BOP_WRITE = 2'd3
  } bop_e;

  typedef struct packed {
    logic [7:0]        rd;
    logic              irq;
    logic              pal_chg;
    logic [4:0]        pal_idx;
    logic [7:0]        pal_val;
    logic [ADDR_W-1:0] name_base;
    logic [ADDR_W-1:0] sprite_base;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/video_display_port_interface.sv @@
`default_nettype none

// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid_i/tready_o   tuser: req_type, port_sel; tdata: write_data, flag_set
// m_axis    out  m_axis_tvalid_o/tready_i   tdata: one result per input transfer
//
// one input transfer per cycle while tready is high
// the first stage updates port state and issues the vram read, the second stage compares and
// writes back the vram byte and fills the output register
// after reset a clearing pass zeroes vram with tready low
// a stalled output holds the second stage, which then holds the input

module video_display_port_interface #(
  parameter int unsigned VRAM_DEPTH = 16384,
  parameter int unsigned CRAM_DEPTH = 32,
  parameter int unsigned REG_COUNT  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // write_data [7:0], flag_set [10:8], zero [15:11]
  input  wire logic [vdpi_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // req_type [1:0], port_sel [2]
  input  wire logic [vdpi_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // read_data [7:0], irq_request [8], pattern_dirty [9], pattern_index [18:10],
  // palette_changed [19], palette_index [24:20], palette_value [32:25],
  // name_table_base [46:33], sprite_table_base [60:47], zero [63:61]
  output logic [vdpi_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o
);

  import vdpi_pkg::*;

  localparam int unsigned VA = $clog2(VRAM_DEPTH);
  localparam int unsigned CA = $clog2(CRAM_DEPTH);

  function automatic logic [VA-1:0] vram_index(input logic [ADDR_W-1:0] a);
    logic [20:0] v;
    v = {7'd0, a & ADDR_MASK};
    for (int k = 4; k >= 0; k--) begin
      if (v >= (21'(VRAM_DEPTH) << k)) begin
        v = v - (21'(VRAM_DEPTH) << k);
      end
    end
    return VA'(v);
  endfunction

  // input fields
  req_e        req;
  logic        port;
  logic [7:0]  data;
  logic [2:0]  flags;
  logic        s_acc;

  assign req   = req_e'(s_axis_tuser_i[1:0]);
  assign port  = s_axis_tuser_i[2];
  assign data  = s_axis_tdata_i[7:0];
  assign flags = s_axis_tdata_i[10:8];

  // port state
  logic              sbe_q, sbe_d;
  logic [7:0]        latch_q, latch_d;
  cmd_e              code_q, code_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [2:0]        status_q, status_d;
  logic [7:0]        regs_q [REG_COUNT];
  logic [7:0]        regs_d [REG_COUNT];
  logic [7:0]        cram_q [CRAM_DEPTH];
  logic [7:0]        cram_d [CRAM_DEPTH];
  logic [7:0]        rbuf_q, rbuf_d;

  // clearing pass
  logic          clr_busy_q;
  logic [VA-1:0] clr_cnt_q;

  // second stage
  logic          bv_q;
  bop_e          b_op_q;
  logic [VA-1:0] b_idx_q;
  logic [7:0]    b_data_q;
  logic          b_hit_q;
  logic [7:0]    b_fwd_q;
  side_t         b_side_q;
  logic          b_move;
  logic          b_we;
  logic [7:0]    vdata;
  logic [7:0]    ram_rdata;

  // output register
  logic                  ov_q;
  logic [OUT_DATA_W-1:0] odata_q, odata_d;

  // first stage decode
  bop_e              a_op;
  logic [ADDR_W-1:0] a_addr;
  logic [VA-1:0]     a_idx;
  side_t             a_side;
  logic [5:0]        c6;
  logic [CA-1:0]     cidx;
  logic [ADDR_W-1:0] new_addr;
  logic [3:0]        reg_num;

  // vram port
  logic          ram_we;
  logic [VA-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign s_axis_tready_o = !clr_busy_q && (!bv_q || b_move);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign b_move          = bv_q && (!ov_q || m_axis_tready_i);

  assign new_addr = {data[5:0], latch_q} & ADDR_MASK;
  assign reg_num  = data[3:0] & REG_MASK;
  assign a_idx    = vram_index(a_addr);

  always_comb begin
    c6 = {1'b0, addr_q[4:0] & CRAM_MASK};
    if (c6 >= 6'(CRAM_DEPTH)) begin
      c6 = c6 - 6'(CRAM_DEPTH);
    end
    cidx = CA'(c6);
  end

  always_comb begin
    sbe_d    = sbe_q;
    latch_d  = latch_q;
    code_d   = code_q;
    addr_d   = addr_q;
    status_d = status_q;
    regs_d   = regs_q;
    cram_d   = cram_q;
    a_op     = BOP_NONE;
    a_addr   = addr_q;
    a_side   = '0;
    if (s_acc) begin
      case (req)
        REQ_WRITE: begin
          if (port) begin
            if (!sbe_q) begin
              latch_d = data;
              sbe_d   = 1'b1;
            end else begin
              sbe_d  = 1'b0;
              code_d = cmd_e'(data[7:6]);
              addr_d = new_addr;
              if (cmd_e'(data[7:6]) == CMD_VRAM_READ) begin
                a_op   = BOP_FILL;
                a_addr = new_addr;
                addr_d = new_addr + 14'd1;
              end else if (cmd_e'(data[7:6]) == CMD_REG_WRITE) begin
                for (int i = 0; i < REG_COUNT; i++) begin
                  if (reg_num == 4'(i)) begin
                    regs_d[i] = latch_q;
                  end
                end
              end
            end
          end else begin
            sbe_d  = 1'b0;
            addr_d = addr_q + 14'd1;
            if (code_q != CMD_CRAM_WRITE) begin
              a_op = BOP_WRITE;
            end else if (cram_q[cidx] != data) begin
              for (int i = 0; i < CRAM_DEPTH; i++) begin
                if (cidx == CA'(i)) begin
                  cram_d[i] = data;
                end
              end
              a_side.pal_chg = 1'b1;
              a_side.pal_idx = 5'(cidx);
              a_side.pal_val = data;
            end
          end
        end
        REQ_READ: begin
          sbe_d = 1'b0;
          if (port) begin
            a_side.rd = {status_q, 5'd0};
            status_d  = 3'd0;
          end else begin
            a_op   = BOP_READ;
            addr_d = addr_q + 14'd1;
          end
        end
        REQ_EVENT: begin
          status_d = status_q | flags;
        end
        default: begin
        end
      endcase
    end
    a_side.irq = (status_d[1] && regs_d[0][4]) || (status_d[2] && regs_d[1][5]);
    a_side.name_base   = (14'(regs_d[2]) << 10) & NAME_MASK;
    a_side.sprite_base = (14'(regs_d[5]) << 7) & SPRITE_MASK;
  end

  assign vdata = b_hit_q ? b_fwd_q : ram_rdata;
  assign b_we  = b_move && (b_op_q == BOP_WRITE) && (vdata != b_data_q);

  always_comb begin
    rbuf_d = rbuf_q;
    if (b_move && (b_op_q == BOP_FILL || b_op_q == BOP_READ)) begin
      rbuf_d = vdata;
    end
  end

  always_comb begin
    logic [7:0] rd;
    logic [8:0] pidx;
    rd   = (b_op_q == BOP_READ) ? rbuf_q : b_side_q.rd;
    pidx = b_we ? 9'(b_idx_q >> 5) : 9'd0;
    odata_d = {3'd0, b_side_q.sprite_base, b_side_q.name_base, b_side_q.pal_val,
               b_side_q.pal_idx, b_side_q.pal_chg, pidx, b_we, b_side_q.irq, rd};
  end

  assign ram_we    = clr_busy_q || b_we;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : b_idx_q;
  assign ram_wdata = clr_busy_q ? 8'd0 : b_data_q;

  vdpi_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_acc && a_op != BOP_NONE),
    .raddr_i (a_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbe_q      <= 1'b0;
      latch_q    <= 8'd0;
      code_q     <= CMD_VRAM_READ;
      addr_q     <= '0;
      status_q   <= 3'd0;
      rbuf_q     <= 8'd0;
      regs_q     <= '{default: 8'd0};
      cram_q     <= '{default: 8'd0};
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      bv_q       <= 1'b0;
      b_op_q     <= BOP_NONE;
      b_hit_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      sbe_q    <= sbe_d;
      latch_q  <= latch_d;
      code_q   <= code_d;
      addr_q   <= addr_d;
      status_q <= status_d;
      rbuf_q   <= rbuf_d;
      regs_q   <= regs_d;
      cram_q   <= cram_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == VA'(VRAM_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s_acc) begin
        bv_q    <= 1'b1;
        b_op_q  <= a_op;
        b_hit_q <= b_we && (b_idx_q == a_idx);
      end else if (b_move) begin
        bv_q <= 1'b0;
      end
      if (b_move) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      b_idx_q  <= a_idx;
      b_data_q <= data;
      b_fwd_q  <= b_data_q;
      b_side_q <= a_side;
    end
    if (b_move) begin
      odata_q <= odata_d;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready_o)
    else $error("input accepted during vram clearing pass");

  a_write_on_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !clr_busy_q) |-> (b_move && b_op_q == BOP_WRITE))
    else $error("vram written outside a second stage write");

  a_clear_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_cnt_q) == VA'(VRAM_DEPTH - 1)))
    else $error("clearing pass ended early");

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && a_op == BOP_NONE) |=> (bv_q && !b_we))
    else $error("non-vram item wrote vram");

endmodule

`default_nettype wire

@@ rtl/vdpi_ram.sv @@
`default_nettype none

module vdpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import vdpi_pkg::*;

  localparam int unsigned VRAM_WORDS     = 16384;
  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned STALL_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic [7:0]        rd;
    logic              irq;
    logic              pat_dirty;
    logic [8:0]        pat_idx;
    logic              pal_chg;
    logic [4:0]        pal_idx;
    logic [7:0]        pal_val;
    logic [ADDR_W-1:0] name_base;
    logic [ADDR_W-1:0] sprite_base;
  } port_result_t;

  class vdp_port_scoreboard;
    bit [7:0]        vram [VRAM_WORDS];
    bit [7:0]        cram [32];
    bit [7:0]        regs [16];
    bit [7:0]        first_byte;
    bit              want_second;
    cmd_e            code;
    bit [ADDR_W-1:0] addr;
    bit [7:0]        prefetch;
    bit [2:0]        status;
    port_result_t    expected_results [$];
    int unsigned     errors;

    function new();
      code = CMD_VRAM_READ;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_access(logic [IN_USER_W-1:0] user, logic [IN_DATA_W-1:0] data);
      req_e            req;
      bit              ctrl;
      bit [7:0]        wd;
      bit [ADDR_W-1:0] base;
      port_result_t    r;
      req  = req_e'(user[1:0]);
      ctrl = user[2];
      wd   = data[7:0];
      r    = '0;
      case (req)
        REQ_WRITE: begin
          if (ctrl) begin
            if (!want_second) begin
              first_byte  = wd;
              want_second = 1'b1;
            end else begin
              want_second = 1'b0;
              code        = cmd_e'(wd[7:6]);
              addr        = {wd[5:0], first_byte};
              if (code == CMD_VRAM_READ) begin
                prefetch = vram[addr];
                addr     = addr + 1'b1;
              end else if (code == CMD_REG_WRITE) begin
                regs[wd[3:0] & REG_MASK] = first_byte;
              end
            end
          end else begin
            want_second = 1'b0;
            if (code != CMD_CRAM_WRITE) begin
              if (vram[addr] != wd) begin
                vram[addr]  = wd;
                r.pat_dirty = 1'b1;
                r.pat_idx   = addr[13:5];
              end
            end else if (cram[addr[4:0] & CRAM_MASK] != wd) begin
              cram[addr[4:0] & CRAM_MASK] = wd;
              r.pal_chg = 1'b1;
              r.pal_idx = addr[4:0] & CRAM_MASK;
              r.pal_val = wd;
            end
            addr = addr + 1'b1;
          end
        end
        REQ_READ: begin
          want_second = 1'b0;
          if (ctrl) begin
            r.rd   = {status, 5'b0};
            status = '0;
          end else begin
            r.rd     = prefetch;
            prefetch = vram[addr];
            addr     = addr + 1'b1;
          end
        end
        REQ_EVENT: status = status | data[10:8];
        default: ;
      endcase
      r.irq = (status[1] && regs[0][4]) || (status[2] && regs[1][5]);
      base = ADDR_W'(regs[2]) << 10;
      r.name_base = base & NAME_MASK;
      base = ADDR_W'(regs[5]) << 7;
      r.sprite_base = base & SPRITE_MASK;
      expected_results.push_back(r);
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] t);
      port_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result: 0x%0h", t);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare("read_data", e.rd, t[7:0]);
      compare("irq_request", e.irq, t[8]);
      compare("pattern_dirty", e.pat_dirty, t[9]);
      compare("pattern_index", e.pat_idx, t[18:10]);
      compare("palette_changed", e.pal_chg, t[19]);
      compare("palette_index", e.pal_idx, t[24:20]);
      compare("palette_value", e.pal_val, t[32:25]);
      compare("name_table_base", e.name_base, t[46:33]);
      compare("sprite_table_base", e.sprite_base, t[60:47]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  vdp_port_scoreboard sb = new();
  bit                 calm;
  bit                 stall_req;
  int unsigned        items_sent;

  video_display_port_interface uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_access(s_axis_tuser_i, s_axis_tdata_i);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  // result side backpressure, with one long hold-off on request
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold      = STALL_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_transfer(req_e req, bit ctrl, bit [7:0] wd, bit [2:0] fl);
    while (!calm && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= {ctrl, req};
    s_axis_tdata_i  <= {5'b0, fl, wd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic control_pair(bit [7:0] lo, bit [7:0] hi);
    send_transfer(REQ_WRITE, 1'b1, lo, 3'($urandom));
    send_transfer(REQ_WRITE, 1'b1, hi, 3'($urandom));
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic bit [ADDR_W-1:0] pick_address();
    case ($urandom_range(3))
      0: return ADDR_W'($urandom_range(63));
      1: return ADDR_W'(16383 - $urandom_range(63));
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned     first_random;
    int unsigned     burst;
    bit              stalled;
    bit              drained;
    bit [ADDR_W-1:0] a;
    bit [1:0]        c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register writes that enable both interrupts and set both table bases
    control_pair(8'h10, 8'h80);
    control_pair(8'h20, 8'h81);
    control_pair(8'hFF, 8'h82);
    control_pair(8'hFF, 8'h85);
    send_transfer(REQ_EVENT, 1'b0, 8'h00, 3'd7);
    send_transfer(REQ_READ, 1'b1, 8'h00, 3'd0);
    // vram write at the top address, then wrap to zero with an unchanged byte
    control_pair(8'hFF, 8'h7F);
    send_transfer(REQ_WRITE, 1'b0, 8'hFF, 3'd0);
    send_transfer(REQ_WRITE, 1'b0, 8'h00, 3'd0);
    // colour ram at its last entry, then wrap of the entry index
    control_pair(8'h1F, 8'hC0);
    send_transfer(REQ_WRITE, 1'b0, 8'hAB, 3'd0);
    send_transfer(REQ_WRITE, 1'b0, 8'h55, 3'd0);
    // prefetch from the top address and read it back
    control_pair(8'hFF, 8'h3F);
    send_transfer(REQ_READ, 1'b0, 8'h00, 3'd0);
    // a data read clears the half-written command, an event does not
    send_transfer(REQ_WRITE, 1'b1, 8'h12, 3'd0);
    send_transfer(REQ_READ, 1'b0, 8'h00, 3'd0);
    send_transfer(REQ_WRITE, 1'b1, 8'h34, 3'd0);
    send_transfer(REQ_NONE, 1'b1, 8'hFF, 3'd7);
    send_transfer(REQ_EVENT, 1'b0, 8'hFF, 3'd0);
    send_transfer(REQ_WRITE, 1'b1, 8'h40, 3'd0);
    send_transfer(REQ_EVENT, 1'b0, 8'h00, 3'd2);

    first_random = items_sent;
    stalled      = 1'b0;
    drained      = 1'b0;
    while (items_sent < first_random + RANDOM_ITEMS) begin
      calm = (items_sent >= first_random + 150) && (items_sent < first_random + 240);
      if (!stalled && items_sent >= first_random + 80) begin
        stalled   = 1'b1;
        stall_req = 1'b1;
      end
      if (!drained && items_sent >= first_random + 300) begin
        drained = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          a = pick_address();
          c = 2'($urandom);
          if (cmd_e'(c) == CMD_REG_WRITE) begin
            control_pair(8'($urandom), {c, 6'($urandom)});
          end else begin
            control_pair(a[7:0], {c, a[13:8]});
          end
          burst = $urandom_range(4, 1);
          repeat (burst) begin
            if (cmd_e'(c) == CMD_VRAM_READ && $urandom_range(1) == 0) begin
              send_transfer(REQ_READ, 1'b0, 8'($urandom), 3'($urandom));
            end else begin
              send_transfer(REQ_WRITE, 1'b0,
                            ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                            3'($urandom));
            end
          end
        end
        4: send_transfer(REQ_WRITE, 1'b0, 8'($urandom), 3'($urandom));
        5: send_transfer(REQ_READ, 1'b0, 8'($urandom), 3'($urandom));
        6: send_transfer(REQ_READ, 1'b1, 8'($urandom), 3'($urandom));
        7: send_transfer(REQ_EVENT, 1'($urandom), 8'($urandom), 3'($urandom));
        8: send_transfer(REQ_WRITE, 1'b1, 8'($urandom), 3'($urandom));
        default: send_transfer(REQ_NONE, 1'($urandom), 8'($urandom), 3'($urandom));
      endcase
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ video_display_port_interface.f @@
rtl/vdpi_pkg.sv
rtl/vdpi_ram.sv
rtl/video_display_port_interface.sv
sim/tb.sv
